FILE: hw/rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types and codes of the SD card SPI-mode sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam int SECTOR_BITS_DEF = 32;
  localparam int BCNT_W          = 13;  // covers the largest block size
  localparam int ST_W            = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  // request kinds
  localparam logic [1:0] KIND_INIT = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_XCHG = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  // result codes
  localparam logic [2:0] RC_OK     = 3'd0;
  localparam logic [2:0] RC_ERROR  = 3'd1;
  localparam logic [2:0] RC_NRDY   = 3'd2;
  localparam logic [2:0] RC_PARAM  = 3'd3;
  localparam logic [2:0] RC_BUSY   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_READY_TO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_TO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_APP_TRIES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PWR_DELAY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_APP_DELAY = 3'd5;

  // sequencer states
  localparam logic [ST_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [ST_W-1:0] ST_PWR_DESEL = 5'd1;
  localparam logic [ST_W-1:0] ST_PWR_WAIT  = 5'd2;
  localparam logic [ST_W-1:0] ST_CLOCKS    = 5'd3;
  localparam logic [ST_W-1:0] ST_CMD_DESEL = 5'd4;
  localparam logic [ST_W-1:0] ST_CMD_READY = 5'd5;
  localparam logic [ST_W-1:0] ST_CMD_FRAME = 5'd6;
  localparam logic [ST_W-1:0] ST_CMD_POLL  = 5'd7;
  localparam logic [ST_W-1:0] ST_CMD_FAIL  = 5'd8;
  localparam logic [ST_W-1:0] ST_APP_DESEL = 5'd9;
  localparam logic [ST_W-1:0] ST_APP_WAIT  = 5'd10;
  localparam logic [ST_W-1:0] ST_APP_NEXT  = 5'd11;
  localparam logic [ST_W-1:0] ST_APP_TRY   = 5'd12;
  localparam logic [ST_W-1:0] ST_RESULT    = 5'd13;
  localparam logic [ST_W-1:0] ST_OCR8      = 5'd14;
  localparam logic [ST_W-1:0] ST_OCR58     = 5'd15;
  localparam logic [ST_W-1:0] ST_TOKEN     = 5'd16;
  localparam logic [ST_W-1:0] ST_DATA      = 5'd17;
  localparam logic [ST_W-1:0] ST_CRC       = 5'd18;
  localparam logic [ST_W-1:0] ST_BLK_DESEL = 5'd19;
  localparam logic [ST_W-1:0] ST_END       = 5'd20;

  // command phases
  localparam logic [2:0] PH_CMD0  = 3'd0;
  localparam logic [2:0] PH_CMD8  = 3'd1;
  localparam logic [2:0] PH_V2    = 3'd2;
  localparam logic [2:0] PH_CMD58 = 3'd3;
  localparam logic [2:0] PH_V1    = 3'd4;
  localparam logic [2:0] PH_CMD16 = 3'd5;
  localparam logic [2:0] PH_CMD17 = 3'd6;

  typedef struct packed {
    logic [15:0] ready_to;
    logic [15:0] init_to;
    logic [7:0]  poll_lim;
    logic [3:0]  app_tries;
    logic [9:0]  pwr_delay;
    logic [7:0]  app_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  drive;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]   st;
    logic [2:0]        phase;
    logic [1:0]        app_stage;
    logic [2:0]        end_code;
    logic [2:0]        card_type;
    logic [2:0]        err_step;
    logic [5:0]        last_cmd;
    logic [7:0]        last_resp;
    logic              not_init;
    logic              use_app;
    logic              blk_ok;
    logic              cs_low;
    logic              awaiting;
    logic [15:0]       elapsed;
    logic [15:0]       init_elapsed;
    logic [BCNT_W-1:0] byte_cnt;
    logic [3:0]        attempt;
    logic [31:0]       ocr;
    logic [31:0]       cmd_arg;
    logic [31:0]       cur_sector;
    logic [15:0]       blocks_left;
    logic [6:0]        pending;
    logic [5:0]        frame_cmd;
    logic [31:0]       frame_arg;
    logic [7:0]        resp_hold;
    logic [7:0]        app_resp;
    logic [7:0]        tx_hold;
  } seq_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       select_active;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       data_last;
    logic       done_res;
    logic [2:0] result_code;
    logic [2:0] card_kind;
    logic [2:0] error_step;
    logic [5:0] last_command;
    logic [7:0] last_response;
  } res_t;

endpackage

FILE: hw/rtl/sdspi_core.sv
// ----------------------------------------------------------------------------
// sdspi_core
// Next-state and result logic of the sequencer for one item.
// ----------------------------------------------------------------------------
module sdspi_core #(
  parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
  parameter int SECTOR_BITS = sdspi_pkg::SECTOR_BITS_DEF
) (
  input  sdspi_pkg::cfg_t  cfg,
  input  sdspi_pkg::seq_t  seq,
  input  sdspi_pkg::item_t item,
  output sdspi_pkg::seq_t  seq_next,
  output sdspi_pkg::res_t  res
);

  localparam int BCNT_LOCAL = sdspi_pkg::BCNT_W;
  localparam logic [31:0] SECTOR_MASK = 32'((64'd1 << SECTOR_BITS) - 64'd1);
  localparam logic [BCNT_LOCAL-1:0] BLK_LAST = BCNT_LOCAL'(BLOCK_BYTES);

  typedef struct packed {
    sdspi_pkg::seq_t s;
    logic            tx_valid;
    logic [7:0]      data;
    logic            dv;
    logic            last;
    logic            done;
    logic [2:0]      code;
  } work_t;

  function automatic work_t xfer(work_t w, logic [7:0] b, logic low, logic [4:0] st);
    w.s.tx_hold  = b;
    w.s.cs_low   = low;
    w.s.awaiting = 1'b1;
    w.s.st       = st;
    w.tx_valid   = 1'b1;
    return w;
  endfunction

  function automatic work_t finish(work_t w, logic [2:0] code);
    w.done = 1'b1;
    w.code = code;
    w.s.st = sdspi_pkg::ST_IDLE;
    return w;
  endfunction

  function automatic logic [7:0] frame_byte(sdspi_pkg::seq_t s, logic [BCNT_LOCAL-1:0] i);
    logic [7:0] b;
    case (i)
      BCNT_LOCAL'(0): b = {2'b01, s.frame_cmd};
      BCNT_LOCAL'(1): b = s.frame_arg[31:24];
      BCNT_LOCAL'(2): b = s.frame_arg[23:16];
      BCNT_LOCAL'(3): b = s.frame_arg[15:8];
      BCNT_LOCAL'(4): b = s.frame_arg[7:0];
      default: b = (s.frame_cmd == 6'd0) ? 8'h95 : ((s.frame_cmd == 6'd8) ? 8'h87 : 8'h01);
    endcase
    return b;
  endfunction

  function automatic work_t raw_cmd(work_t w, logic [5:0] c, logic [31:0] a);
    w.s.frame_cmd = c;
    w.s.frame_arg = a;
    w.s.last_cmd  = c;
    return xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_CMD_DESEL);
  endfunction

  function automatic work_t start_cmd(work_t w, logic [5:0] c, logic [31:0] a, logic app,
                                      logic [2:0] ph);
    w.s.pending = {app, c};
    w.s.cmd_arg = a;
    w.s.phase   = ph;
    if (app) begin
      w.s.attempt  = 4'd0;
      w.s.app_resp = 8'hFF;
      w.s.st       = sdspi_pkg::ST_APP_TRY;
    end else begin
      w.s.app_stage = 2'd0;
      w = raw_cmd(w, c, a);
    end
    return w;
  endfunction

  function automatic work_t init_final(work_t w);
    w.s.not_init = (w.s.card_type == 3'd0);
    if (w.s.not_init) w.s.err_step = 3'd5;
    w.s.end_code = w.s.not_init ? sdspi_pkg::RC_NRDY : sdspi_pkg::RC_OK;
    return xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_END);
  endfunction

  function automatic work_t init_fail(work_t w, logic [2:0] step);
    w.s.err_step = step;
    w.s.not_init = 1'b1;
    w.s.end_code = sdspi_pkg::RC_NRDY;
    return xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_END);
  endfunction

  function automatic work_t read_block(work_t w);
    logic [31:0] addr;
    addr = w.s.cur_sector;
    // byte addressing unless the card is block addressed
    if (!w.s.card_type[2]) addr = 32'(64'(addr) * 64'(BLOCK_BYTES));
    return start_cmd(w, 6'd17, addr, 1'b0, sdspi_pkg::PH_CMD17);
  endfunction

  function automatic work_t block_fail(work_t w);
    w.s.blk_ok = 1'b0;
    return xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_BLK_DESEL);
  endfunction

  function automatic work_t on_result(work_t w, logic [7:0] r);
    logic [5:0] v1cmd;
    logic       init_live;
    v1cmd     = w.s.use_app ? 6'd41 : 6'd1;
    init_live = (w.s.init_elapsed < cfg.init_to);
    case (w.s.phase)
      sdspi_pkg::PH_CMD0: begin
        if (r != 8'd1) w = init_fail(w, 3'd2);
        else w = start_cmd(w, 6'd8, 32'h1AA, 1'b0, sdspi_pkg::PH_CMD8);
      end
      sdspi_pkg::PH_CMD8: begin
        if (r == 8'd1) begin
          w.s.byte_cnt = '0;
          w.s.ocr      = '0;
          w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_OCR8);
        end else begin
          w.s.use_app      = (r == 8'h05);
          w.s.init_elapsed = '0;
          w = start_cmd(w, (r == 8'h05) ? 6'd41 : 6'd1, 32'd0, r == 8'h05,
                        sdspi_pkg::PH_V1);
        end
      end
      sdspi_pkg::PH_V2: begin
        if (r != 8'd0 && init_live)
          w = start_cmd(w, 6'd41, 32'h4000_0000, 1'b1, sdspi_pkg::PH_V2);
        else if (r == 8'd0) w = start_cmd(w, 6'd58, 32'd0, 1'b0, sdspi_pkg::PH_CMD58);
        else begin
          w.s.err_step = 3'd4;
          w = init_final(w);
        end
      end
      sdspi_pkg::PH_CMD58: begin
        if (r == 8'd0) begin
          w.s.byte_cnt = '0;
          w.s.ocr      = '0;
          w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_OCR58);
        end else begin
          w.s.err_step = 3'd4;
          w = init_final(w);
        end
      end
      sdspi_pkg::PH_V1: begin
        if (r != 8'd0 && init_live)
          w = start_cmd(w, v1cmd, 32'd0, w.s.use_app, sdspi_pkg::PH_V1);
        else if (r == 8'd0)
          w = start_cmd(w, 6'd16, 32'(BLOCK_BYTES), 1'b0, sdspi_pkg::PH_CMD16);
        else w = init_final(w);
      end
      sdspi_pkg::PH_CMD16: begin
        if (r == 8'd0) w.s.card_type = 3'd1;
        w = init_final(w);
      end
      default: begin
        if (r == 8'd0) begin
          w.s.elapsed = '0;
          w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_TOKEN);
        end else w = block_fail(w);
      end
    endcase
    return w;
  endfunction

  // one pass of the internal chain of states that take no exchange
  function automatic work_t settle1(work_t w);
    logic [3:0] lim;
    logic [7:0] r;
    lim = (cfg.app_tries == 4'd0) ? 4'd1 : cfg.app_tries;
    r   = w.s.resp_hold;
    case (w.s.st)
      sdspi_pkg::ST_APP_NEXT: begin
        w.s.attempt = w.s.attempt + 4'd1;
        w.s.st      = sdspi_pkg::ST_APP_TRY;
      end
      sdspi_pkg::ST_APP_TRY: begin
        if (w.s.attempt >= lim) begin
          w.s.app_stage = 2'd0;
          w.s.resp_hold = w.s.app_resp;
          w.s.st        = sdspi_pkg::ST_RESULT;
        end else begin
          w.s.app_stage = 2'd1;
          w = raw_cmd(w, 6'd55, 32'd0);
        end
      end
      sdspi_pkg::ST_RESULT: begin
        if (w.s.app_stage == 2'd1) begin
          if (r <= 8'd1) begin
            w.s.app_stage = 2'd2;
            w = raw_cmd(w, w.s.pending[5:0], w.s.cmd_arg);
          end else begin
            w.s.app_resp = r;
            w = xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_APP_DESEL);
          end
        end else w = on_result(w, r);
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic work_t on_exchange(work_t w, logic [7:0] rx);
    logic [7:0]        lim;
    logic [BCNT_LOCAL-1:0] bc;
    lim = (cfg.poll_lim == 8'd0) ? 8'd1 : cfg.poll_lim;
    bc  = w.s.byte_cnt + BCNT_LOCAL'(1);
    case (w.s.st)
      sdspi_pkg::ST_PWR_DESEL: begin
        w.s.elapsed = '0;
        if (cfg.pwr_delay == 10'd0) begin
          w.s.byte_cnt = '0;
          w = xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_CLOCKS);
        end else w.s.st = sdspi_pkg::ST_PWR_WAIT;
      end
      sdspi_pkg::ST_CLOCKS: begin
        w.s.byte_cnt = bc;
        if (bc < BCNT_LOCAL'(10)) w = xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_CLOCKS);
        else w = start_cmd(w, 6'd0, 32'd0, 1'b0, sdspi_pkg::PH_CMD0);
      end
      sdspi_pkg::ST_CMD_DESEL: begin
        w.s.elapsed = '0;
        w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_CMD_READY);
      end
      sdspi_pkg::ST_CMD_READY: begin
        if (rx == 8'hFF) begin
          w.s.byte_cnt = '0;
          w = xfer(w, frame_byte(w.s, '0), 1'b1, sdspi_pkg::ST_CMD_FRAME);
        end else if (w.s.elapsed >= cfg.ready_to)
          w = xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_CMD_FAIL);
        else w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_CMD_READY);
      end
      sdspi_pkg::ST_CMD_FRAME: begin
        w.s.byte_cnt = bc;
        if (bc < BCNT_LOCAL'(6))
          w = xfer(w, frame_byte(w.s, bc), 1'b1, sdspi_pkg::ST_CMD_FRAME);
        else begin
          w.s.byte_cnt = '0;
          w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_CMD_POLL);
        end
      end
      sdspi_pkg::ST_CMD_POLL: begin
        if (!rx[7]) begin
          w.s.last_resp = rx;
          w.s.resp_hold = rx;
          w.s.st        = sdspi_pkg::ST_RESULT;
        end else begin
          w.s.byte_cnt = bc;
          if (bc >= BCNT_LOCAL'(lim)) begin
            w.s.last_resp = 8'hFF;
            w.s.resp_hold = 8'hFF;
            w.s.st        = sdspi_pkg::ST_RESULT;
          end else w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_CMD_POLL);
        end
      end
      sdspi_pkg::ST_CMD_FAIL: begin
        w.s.resp_hold = 8'hFF;
        w.s.st        = sdspi_pkg::ST_RESULT;
      end
      sdspi_pkg::ST_APP_DESEL: begin
        w.s.elapsed = '0;
        w.s.st = (cfg.app_delay == 8'd0) ? sdspi_pkg::ST_APP_NEXT : sdspi_pkg::ST_APP_WAIT;
      end
      sdspi_pkg::ST_OCR8, sdspi_pkg::ST_OCR58: begin
        w.s.ocr      = {w.s.ocr[23:0], rx};
        w.s.byte_cnt = bc;
        if (bc < BCNT_LOCAL'(4)) w = xfer(w, 8'hFF, 1'b1, w.s.st);
        else if (w.s.st == sdspi_pkg::ST_OCR8) begin
          if (w.s.ocr[15:0] != 16'h01AA) w = init_fail(w, 3'd3);
          else begin
            w.s.init_elapsed = '0;
            w = start_cmd(w, 6'd41, 32'h4000_0000, 1'b1, sdspi_pkg::PH_V2);
          end
        end else begin
          w.s.card_type = {w.s.ocr[30], 2'b10};
          w = init_final(w);
        end
      end
      sdspi_pkg::ST_TOKEN: begin
        if (rx == 8'hFE) begin
          w.s.byte_cnt = '0;
          w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_DATA);
        end else if (w.s.elapsed >= cfg.ready_to) w = block_fail(w);
        else w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_TOKEN);
      end
      sdspi_pkg::ST_DATA: begin
        w.data       = rx;
        w.dv         = 1'b1;
        w.s.byte_cnt = bc;
        if (bc >= BLK_LAST) begin
          w.last       = (w.s.blocks_left == 16'd1);
          w.s.byte_cnt = '0;
          w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_CRC);
        end else w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_DATA);
      end
      sdspi_pkg::ST_CRC: begin
        w.s.byte_cnt = bc;
        if (bc < BCNT_LOCAL'(2)) w = xfer(w, 8'hFF, 1'b1, sdspi_pkg::ST_CRC);
        else begin
          w.s.blk_ok = 1'b1;
          w = xfer(w, 8'hFF, 1'b0, sdspi_pkg::ST_BLK_DESEL);
        end
      end
      sdspi_pkg::ST_BLK_DESEL: begin
        if (!w.s.blk_ok) w = finish(w, sdspi_pkg::RC_ERROR);
        else begin
          w.s.blocks_left = w.s.blocks_left - 16'd1;
          w.s.cur_sector  = (w.s.cur_sector + 32'd1) & SECTOR_MASK;
          if (w.s.blocks_left == 16'd0) w = finish(w, sdspi_pkg::RC_OK);
          else w = read_block(w);
        end
      end
      sdspi_pkg::ST_END: w = finish(w, w.s.end_code);
      default: ;
    endcase
    return w;
  endfunction

  work_t w0, w1, w2, w3, w4;

  always_comb begin
    w0          = '0;
    w0.s        = seq;
    case (item.kind)
      sdspi_pkg::KIND_INIT, sdspi_pkg::KIND_READ: begin
        if (seq.st != sdspi_pkg::ST_IDLE) begin
          w0.done = 1'b1;
          w0.code = sdspi_pkg::RC_BUSY;
        end else if (item.kind == sdspi_pkg::KIND_INIT) begin
          if (item.drive != 8'd0) begin
            w0.s.err_step = 3'd1;
            w0.done       = 1'b1;
            w0.code       = sdspi_pkg::RC_NRDY;
          end else begin
            w0.s.err_step  = 3'd0;
            w0.s.card_type = 3'd0;
            w0 = xfer(w0, 8'hFF, 1'b0, sdspi_pkg::ST_PWR_DESEL);
          end
        end else if (item.drive != 8'd0 || item.block_count == 16'd0) begin
          w0.done = 1'b1;
          w0.code = sdspi_pkg::RC_PARAM;
        end else if (seq.not_init) begin
          w0.done = 1'b1;
          w0.code = sdspi_pkg::RC_NRDY;
        end else begin
          w0.s.blocks_left = item.block_count;
          w0.s.cur_sector  = item.sector & SECTOR_MASK;
          w0 = read_block(w0);
        end
      end
      sdspi_pkg::KIND_XCHG: begin
        if (seq.awaiting) begin
          w0.s.awaiting = 1'b0;
          w0 = on_exchange(w0, item.rx_byte);
        end
      end
      default: begin
        if (seq.elapsed != 16'hFFFF) w0.s.elapsed = seq.elapsed + 16'd1;
        if (seq.init_elapsed != 16'hFFFF) w0.s.init_elapsed = seq.init_elapsed + 16'd1;
        if (seq.st == sdspi_pkg::ST_PWR_WAIT && w0.s.elapsed >= 16'(cfg.pwr_delay)) begin
          w0.s.byte_cnt = '0;
          w0 = xfer(w0, 8'hFF, 1'b0, sdspi_pkg::ST_CLOCKS);
        end else if (seq.st == sdspi_pkg::ST_APP_WAIT &&
                     w0.s.elapsed >= 16'(cfg.app_delay)) begin
          w0.s.st = sdspi_pkg::ST_APP_NEXT;
        end
      end
    endcase
    // at most four chained internal steps: next try, try, result, new app command
    w1 = settle1(w0);
    w2 = settle1(w1);
    w3 = settle1(w2);
    w4 = settle1(w3);

    seq_next              = w4.s;
    res.tx_byte           = w4.tx_valid ? w4.s.tx_hold : 8'hFF;
    res.tx_valid          = w4.tx_valid;
    res.select_active     = w4.s.cs_low;
    res.data_byte         = w4.data;
    res.data_valid        = w4.dv;
    res.data_last         = w4.last;
    res.done_res          = w4.done;
    res.result_code       = w4.code;
    res.card_kind         = w4.s.card_type;
    res.error_step        = w4.s.err_step;
    res.last_command      = w4.s.last_cmd;
    res.last_response     = w4.s.last_resp;
  end

endmodule

FILE: hw/rtl/sd_spi_init_and_block_read.sv
// ----------------------------------------------------------------------------
// sd_spi_init_and_block_read
// SD card SPI-mode host sequencer: power-up, init and block reads.
// ----------------------------------------------------------------------------
// Each input request (init, read, completed byte exchange, millisecond tick)
// yields exactly one result that names the next SPI byte to send, the chip
// select level, any block data byte and status. The block takes one request
// per clock: a request is registered, the sequencer step is one pass of
// logic, and the result waits in an output register, so the sustained rate is
// one request per cycle, and a result passes the input and then the output
// register before it is offered; the rate drops only while the result
// register is stalled by the downstream side.
module sd_spi_init_and_block_read #(
  parameter int BLOCK_BYTES = sdspi_pkg::BLOCK_BYTES_DEF,
  parameter int SECTOR_BITS = sdspi_pkg::SECTOR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // drive, sector, block_count, rx_byte
  input  logic [1:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // tx_byte, tx_valid, select_active, data_byte,
                                // data_valid, done_res, result_code, card_kind,
                                // error_step, last_command, last_response
  output logic        m_tlast,  // data_last
  input  logic        cfg_we,
  input  logic [sdspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdspi_pkg::CFG_DATA_W-1:0] cfg_data
);

  sdspi_pkg::cfg_t  cfg;
  sdspi_pkg::seq_t  seq, seq_next, seq_rst;
  sdspi_pkg::item_t in_item;
  sdspi_pkg::res_t  out_res, res;
  logic             in_valid, out_valid, advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_comb begin
    seq_rst           = '0;
    seq_rst.st        = sdspi_pkg::ST_IDLE;
    seq_rst.not_init  = 1'b1;
    seq_rst.last_resp = 8'hFF;
    seq_rst.app_resp  = 8'hFF;
    seq_rst.tx_hold   = 8'hFF;
  end

  sdspi_core #(.BLOCK_BYTES(BLOCK_BYTES), .SECTOR_BITS(SECTOR_BITS)) u_core (
    .cfg(cfg), .seq(seq), .item(in_item), .seq_next(seq_next), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{ready_to: 16'd1000, init_to: 16'd10000, poll_lim: 8'd10,
               app_tries: 4'd5, pwr_delay: 10'd100, app_delay: 8'd10};
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdspi_pkg::REG_READY_TO:  cfg.ready_to  <= cfg_data;
        sdspi_pkg::REG_INIT_TO:   cfg.init_to   <= cfg_data;
        sdspi_pkg::REG_POLL_LIM:  cfg.poll_lim  <= cfg_data[7:0];
        sdspi_pkg::REG_APP_TRIES: cfg.app_tries <= cfg_data[3:0];
        sdspi_pkg::REG_PWR_DELAY: cfg.pwr_delay <= cfg_data[9:0];
        sdspi_pkg::REG_APP_DELAY: cfg.app_delay <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      seq       <= seq_rst;
    end else begin
      if (s_tvalid && s_tready) in_valid <= 1'b1;
      else if (advance) in_valid <= 1'b0;
      if (advance) begin
        out_valid <= 1'b1;
        seq       <= seq_next;
      end else if (m_tready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= '{kind: s_tuser, drive: s_tdata[7:0], sector: s_tdata[39:8],
                   block_count: s_tdata[55:40], rx_byte: s_tdata[63:56]};
    end
    if (advance) out_res <= res;
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.data_last;
  assign m_tdata  = {5'd0, out_res.last_response, out_res.last_command, out_res.error_step,
                     out_res.card_kind, out_res.result_code, out_res.done_res,
                     out_res.data_valid, out_res.data_byte, out_res.select_active,
                     out_res.tx_valid, out_res.tx_byte};

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.data_last |-> out_res.data_valid)
    else $error("data_last without data byte");
  a_data_selected: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.data_valid |-> out_res.select_active)
    else $error("data byte while card deselected");
  a_code_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.done_res |-> out_res.result_code == sdspi_pkg::RC_OK)
    else $error("result code without done");
  a_in_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_item))
    else $error("registered request lost");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SD card SPI-mode init and block read sequencer.
// A card emulator answers every byte exchange that the sequencer asks for, so
// most requests are well-formed init and read sequences with random content.
// A small noise share adds stray, busy and refused requests. Each request is
// run through a local model of the sequencer, and every result is compared
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
  import sdspi_pkg::*;

  localparam int BLK = BLOCK_BYTES_DEF;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  drive;
    logic [31:0] sector;
    logic [15:0] count;
    logic [7:0]  rx;
    bit          chk;
    logic        done;
    logic [2:0]  code;
    logic [2:0]  err;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  res_t        pending_results[$];
  int          fails = 0;
  int          results_seen = 0;
  int          items_sent = 0;

  // model configuration
  int unsigned c_ready_to, c_init_to, c_poll, c_tries, c_pwr, c_app_delay;

  // model state
  logic [4:0]  sq_state;
  logic [2:0]  sq_phase, sq_end;
  logic [1:0]  sq_stage;
  logic [2:0]  sq_card, sq_err;
  logic [5:0]  sq_lastcmd, sq_fcmd;
  logic [7:0]  sq_lastresp, sq_rhold, sq_aresp, sq_txh, sq_pend;
  bit          sq_notinit, sq_useapp, sq_blkok, sq_csl, sq_await;
  int unsigned sq_elapsed, sq_ielapsed, sq_bcnt, sq_attempt, sq_left;
  logic [31:0] sq_ocr, sq_carg, sq_cursec, sq_farg;
  bit          o_txv, o_dv, o_last, o_done;
  logic [7:0]  o_data;
  logic [2:0]  o_code;

  sd_spi_init_and_block_read dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic void model_reset();
    c_ready_to = 1000; c_init_to = 10000; c_poll = 10;
    c_tries = 5; c_pwr = 100; c_app_delay = 10;
    sq_state = ST_IDLE; sq_phase = PH_CMD0; sq_stage = 0; sq_end = 0;
    sq_card = 0; sq_err = 0; sq_lastcmd = 0; sq_lastresp = 8'hFF;
    sq_notinit = 1; sq_useapp = 0; sq_blkok = 0; sq_csl = 0; sq_await = 0;
    sq_elapsed = 0; sq_ielapsed = 0; sq_bcnt = 0; sq_attempt = 0;
    sq_ocr = 0; sq_carg = 0; sq_cursec = 0; sq_left = 0;
    sq_pend = 0; sq_fcmd = 0; sq_farg = 0; sq_rhold = 0; sq_aresp = 8'hFF;
    sq_txh = 8'hFF;
  endfunction

  function automatic void xfer(logic [7:0] b, bit low, logic [4:0] st);
    sq_txh = b; sq_csl = low; sq_await = 1; sq_state = st; o_txv = 1;
  endfunction

  function automatic void finish_req(logic [2:0] code);
    o_done = 1; o_code = code; sq_state = ST_IDLE;
  endfunction

  function automatic void give_result(logic [7:0] r);
    sq_rhold = r; sq_state = ST_RESULT;
  endfunction

  function automatic logic [7:0] frame_byte(int unsigned i);
    case (i)
      0: return 8'h40 | sq_fcmd;
      1: return sq_farg[31:24];
      2: return sq_farg[23:16];
      3: return sq_farg[15:8];
      4: return sq_farg[7:0];
      default: return sq_fcmd == 0 ? 8'h95 : (sq_fcmd == 8 ? 8'h87 : 8'h01);
    endcase
  endfunction

  function automatic void raw_cmd(logic [5:0] c, logic [31:0] a);
    sq_fcmd = c; sq_farg = a; sq_lastcmd = c;
    xfer(8'hFF, 0, ST_CMD_DESEL);
  endfunction

  function automatic void start_cmd(logic [5:0] c, logic [31:0] a, bit app, logic [2:0] ph);
    sq_pend = {1'b0, app, c};
    sq_carg = a; sq_phase = ph;
    if (app) begin
      sq_attempt = 0; sq_aresp = 8'hFF; sq_state = ST_APP_TRY;
    end else begin
      sq_stage = 0; raw_cmd(c, a);
    end
  endfunction

  function automatic void init_final();
    sq_notinit = (sq_card == 0);
    if (sq_notinit) sq_err = 5;
    sq_end = sq_notinit ? RC_NRDY : RC_OK;
    xfer(8'hFF, 0, ST_END);
  endfunction

  function automatic void init_fail(logic [2:0] step);
    sq_err = step; sq_notinit = 1; sq_end = RC_NRDY;
    xfer(8'hFF, 0, ST_END);
  endfunction

  function automatic void read_block();
    logic [31:0] addr;
    addr = sq_cursec;
    if (!sq_card[2]) addr = sq_cursec * BLK;
    start_cmd(17, addr, 0, PH_CMD17);
  endfunction

  function automatic void on_r1(logic [7:0] r);
    logic [5:0] v1cmd;
    v1cmd = sq_useapp ? 6'd41 : 6'd1;
    case (sq_phase)
      PH_CMD0: begin
        if (r != 1) init_fail(2); else start_cmd(8, 32'h1AA, 0, PH_CMD8);
      end
      PH_CMD8: begin
        if (r == 1) begin
          sq_bcnt = 0; sq_ocr = 0; xfer(8'hFF, 1, ST_OCR8);
        end else begin
          sq_useapp = (r == 8'h05); sq_ielapsed = 0;
          start_cmd(sq_useapp ? 6'd41 : 6'd1, 0, sq_useapp, PH_V1);
        end
      end
      PH_V2: begin
        if (r != 0 && sq_ielapsed < c_init_to) start_cmd(41, 32'h40000000, 1, PH_V2);
        else if (r == 0) start_cmd(58, 0, 0, PH_CMD58);
        else begin
          sq_err = 4; init_final();
        end
      end
      PH_CMD58: begin
        if (r == 0) begin
          sq_bcnt = 0; sq_ocr = 0; xfer(8'hFF, 1, ST_OCR58);
        end else begin
          sq_err = 4; init_final();
        end
      end
      PH_V1: begin
        if (r != 0 && sq_ielapsed < c_init_to) start_cmd(v1cmd, 0, sq_useapp, PH_V1);
        else if (r == 0) start_cmd(16, BLK, 0, PH_CMD16);
        else init_final();
      end
      PH_CMD16: begin
        if (r == 0) sq_card = 1;
        init_final();
      end
      default: begin
        if (r == 0) begin
          sq_elapsed = 0; xfer(8'hFF, 1, ST_TOKEN);
        end else begin
          sq_blkok = 0; xfer(8'hFF, 0, ST_BLK_DESEL);
        end
      end
    endcase
  endfunction

  // resolve the internal states that take no exchange
  function automatic void settle();
    bit busy;
    int unsigned lim;
    busy = 1;
    while (busy) begin
      if (sq_state == ST_APP_NEXT) begin
        sq_attempt++; sq_state = ST_APP_TRY;
      end else if (sq_state == ST_APP_TRY) begin
        lim = c_tries != 0 ? c_tries : 1;
        if (sq_attempt >= lim) begin
          sq_stage = 0; give_result(sq_aresp);
        end else begin
          sq_stage = 1; raw_cmd(55, 0);
        end
      end else if (sq_state == ST_RESULT) begin
        if (sq_stage == 1) begin
          if (sq_rhold <= 1) begin
            sq_stage = 2; raw_cmd(sq_pend[5:0], sq_carg);
          end else begin
            sq_aresp = sq_rhold; xfer(8'hFF, 0, ST_APP_DESEL);
          end
        end else begin
          on_r1(sq_rhold);
        end
      end else begin
        busy = 0;
      end
    end
  endfunction

  function automatic void on_exchange(logic [7:0] rx);
    int unsigned lim;
    case (sq_state)
      ST_PWR_DESEL: begin
        sq_elapsed = 0;
        if (c_pwr == 0) begin
          sq_bcnt = 0; xfer(8'hFF, 0, ST_CLOCKS);
        end else sq_state = ST_PWR_WAIT;
      end
      ST_CLOCKS: begin
        sq_bcnt++;
        if (sq_bcnt < 10) xfer(8'hFF, 0, ST_CLOCKS);
        else start_cmd(0, 0, 0, PH_CMD0);
      end
      ST_CMD_DESEL: begin
        sq_elapsed = 0; xfer(8'hFF, 1, ST_CMD_READY);
      end
      ST_CMD_READY: begin
        if (rx == 8'hFF) begin
          sq_bcnt = 0; xfer(frame_byte(0), 1, ST_CMD_FRAME);
        end else if (sq_elapsed >= c_ready_to) xfer(8'hFF, 0, ST_CMD_FAIL);
        else xfer(8'hFF, 1, ST_CMD_READY);
      end
      ST_CMD_FRAME: begin
        sq_bcnt++;
        if (sq_bcnt < 6) xfer(frame_byte(sq_bcnt), 1, ST_CMD_FRAME);
        else begin
          sq_bcnt = 0; xfer(8'hFF, 1, ST_CMD_POLL);
        end
      end
      ST_CMD_POLL: begin
        lim = c_poll != 0 ? c_poll : 1;
        if (!rx[7]) begin
          sq_lastresp = rx; give_result(rx);
        end else begin
          sq_bcnt++;
          if (sq_bcnt >= lim) begin
            sq_lastresp = 8'hFF; give_result(8'hFF);
          end else xfer(8'hFF, 1, ST_CMD_POLL);
        end
      end
      ST_CMD_FAIL: give_result(8'hFF);
      ST_APP_DESEL: begin
        sq_elapsed = 0;
        sq_state = c_app_delay == 0 ? ST_APP_NEXT : ST_APP_WAIT;
      end
      ST_OCR8, ST_OCR58: begin
        sq_ocr = {sq_ocr[23:0], rx};
        sq_bcnt++;
        if (sq_bcnt < 4) xfer(8'hFF, 1, sq_state);
        else if (sq_state == ST_OCR8) begin
          if (sq_ocr[15:0] != 16'h1AA) init_fail(3);
          else begin
            sq_ielapsed = 0; start_cmd(41, 32'h40000000, 1, PH_V2);
          end
        end else begin
          sq_card = {sq_ocr[30], 2'b10};
          init_final();
        end
      end
      ST_TOKEN: begin
        if (rx == 8'hFE) begin
          sq_bcnt = 0; xfer(8'hFF, 1, ST_DATA);
        end else if (sq_elapsed >= c_ready_to) begin
          sq_blkok = 0; xfer(8'hFF, 0, ST_BLK_DESEL);
        end else xfer(8'hFF, 1, ST_TOKEN);
      end
      ST_DATA: begin
        o_data = rx; o_dv = 1;
        sq_bcnt++;
        if (sq_bcnt >= BLK) begin
          o_last = (sq_left == 1);
          sq_bcnt = 0; xfer(8'hFF, 1, ST_CRC);
        end else xfer(8'hFF, 1, ST_DATA);
      end
      ST_CRC: begin
        sq_bcnt++;
        if (sq_bcnt < 2) xfer(8'hFF, 1, ST_CRC);
        else begin
          sq_blkok = 1; xfer(8'hFF, 0, ST_BLK_DESEL);
        end
      end
      ST_BLK_DESEL: begin
        if (!sq_blkok) finish_req(RC_ERROR);
        else begin
          sq_left = (sq_left - 1) & 16'hFFFF;
          sq_cursec = sq_cursec + 1;
          if (sq_left == 0) finish_req(RC_OK); else read_block();
        end
      end
      ST_END: finish_req(sq_end);
      default: ;
    endcase
  endfunction

  function automatic res_t seq_predict(item_t it);
    res_t r;
    o_txv = 0; o_data = 0; o_dv = 0; o_last = 0; o_done = 0; o_code = 0;
    if (it.kind == KIND_INIT || it.kind == KIND_READ) begin
      if (sq_state != ST_IDLE) begin
        o_done = 1; o_code = RC_BUSY;
      end else if (it.kind == KIND_INIT) begin
        if (it.drive != 0) begin
          sq_err = 1; o_done = 1; o_code = RC_NRDY;
        end else begin
          sq_err = 0; sq_card = 0; xfer(8'hFF, 0, ST_PWR_DESEL);
        end
      end else begin
        if (it.drive != 0 || it.block_count == 0) begin
          o_done = 1; o_code = RC_PARAM;
        end else if (sq_notinit) begin
          o_done = 1; o_code = RC_NRDY;
        end else begin
          sq_left = it.block_count; sq_cursec = it.sector;
          read_block();
        end
      end
    end else if (it.kind == KIND_XCHG) begin
      if (sq_await) begin
        sq_await = 0; on_exchange(it.rx_byte);
      end
    end else begin
      if (sq_elapsed < 16'hFFFF) sq_elapsed++;
      if (sq_ielapsed < 16'hFFFF) sq_ielapsed++;
      if (sq_state == ST_PWR_WAIT && sq_elapsed >= c_pwr) begin
        sq_bcnt = 0; xfer(8'hFF, 0, ST_CLOCKS);
      end else if (sq_state == ST_APP_WAIT && sq_elapsed >= c_app_delay) begin
        sq_state = ST_APP_NEXT;
      end
    end
    settle();
    r.tx_byte = o_txv ? sq_txh : 8'hFF;
    r.tx_valid = o_txv;
    r.select_active = sq_csl;
    r.data_byte = o_data;
    r.data_valid = o_dv;
    r.data_last = o_last;
    r.done_res = o_done;
    r.result_code = o_code;
    r.card_kind = sq_card;
    r.error_step = sq_err;
    r.last_command = sq_lastcmd;
    r.last_response = sq_lastresp;
    return r;
  endfunction

  // ---------------------------------------------------------------- card side
  function automatic logic [7:0] card_answer();
    int p;
    p = $urandom_range(0, 99);
    case (sq_state)
      ST_CMD_READY: return p < 85 ? 8'hFF : 8'($urandom_range(0, 254));
      ST_CMD_POLL: begin
        if (p < 15) return 8'hFF;
        if (p < 20) return 8'($urandom);
        case (sq_fcmd)
          0: return p < 95 ? 8'h01 : 8'h00;
          8: return p < 70 ? 8'h01 : (p < 92 ? 8'h05 : 8'h04);
          55: return p < 88 ? 8'h01 : 8'h05;
          41, 1: return p < 60 ? 8'h00 : 8'h01;
          default: return p < 92 ? 8'h00 : 8'h04;
        endcase
      end
      ST_OCR8: begin
        if (p < 8) return 8'($urandom);
        case (sq_bcnt)
          0, 1: return 8'h00;
          2: return 8'h01;
          default: return 8'hAA;
        endcase
      end
      ST_TOKEN: return p < 70 ? 8'hFE : 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic item_t next_item(bit draining);
    item_t it;
    int p;
    p = $urandom_range(0, 99);
    it.kind = KIND_XCHG;
    it.drive = 8'($urandom);
    it.sector = $urandom;
    it.block_count = 16'($urandom);
    it.rx_byte = 8'($urandom);
    if (!draining && p < 6) begin
      it.kind = 2'($urandom);
    end else if (sq_await) begin
      if (p < 90) it.rx_byte = card_answer();
      else it.kind = KIND_TICK;
    end else if (sq_state != ST_IDLE) begin
      it.kind = KIND_TICK;
    end else if (p < 60) begin
      it.kind = KIND_INIT;
      if (p > 8) it.drive = 0;
    end else if (p < 85) begin
      it.kind = KIND_READ;
      it.drive = 0;
      if (p < 70) it.sector = 32'hFFFF_FFFF;
      it.block_count = p < 82 ? 16'd1 : 16'd2;
    end else begin
      it.kind = KIND_READ;
      if (p < 92) it.block_count = 0; else it.drive = 8'($urandom_range(1, 255));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_item(item_t it, bit force_typed, dir_row_t row);
    res_t e;
    int gap;
    e = seq_predict(it);
    if (force_typed) begin
      e.done_res = row.done; e.result_code = row.code; e.error_step = row.err;
    end
    pending_results.push_back(e);
    s_tvalid <= 1'b1;
    s_tuser <= it.kind;
    s_tdata <= {it.rx_byte, it.block_count, it.sector, it.drive};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    gap = (items_sent > 400 && items_sent < 700) ? 0 :
          ($urandom_range(0, 99) < 33 ? $urandom_range(1, 3) : 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_random(int budget);
    int n;
    bit draining;
    dir_row_t none;
    n = 0;
    draining = 0;
    none = '{default: 0};
    while (!draining || sq_state != ST_IDLE) begin
      send_item(next_item(draining), 0, none);
      n++;
      if (n >= budget) draining = 1;
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_regs(int unsigned v[6]);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= CFG_DATA_W'(v[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    c_ready_to = v[REG_READY_TO] & 16'hFFFF;
    c_init_to = v[REG_INIT_TO] & 16'hFFFF;
    c_poll = v[REG_POLL_LIM] & 8'hFF;
    c_tries = v[REG_APP_TRIES] & 4'hF;
    c_pwr = v[REG_PWR_DELAY] & 10'h3FF;
    c_app_delay = v[REG_APP_DELAY] & 8'hFF;
  endtask

  // ---------------------------------------------------------------- checking
  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  int hold_left = 0;
  bit hold_done = 0;

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, m_tdata);
          fails++;
        end else begin
          e = pending_results.pop_front();
          cmp("tx_byte", e.tx_byte, m_tdata[7:0]);
          cmp("tx_valid", e.tx_valid, m_tdata[8]);
          cmp("select_active", e.select_active, m_tdata[9]);
          cmp("data_byte", e.data_byte, m_tdata[17:10]);
          cmp("data_valid", e.data_valid, m_tdata[18]);
          cmp("done_res", e.done_res, m_tdata[19]);
          cmp("result_code", e.result_code, m_tdata[22:20]);
          cmp("card_kind", e.card_kind, m_tdata[25:23]);
          cmp("error_step", e.error_step, m_tdata[28:26]);
          cmp("last_command", e.last_command, m_tdata[34:29]);
          cmp("last_response", e.last_response, m_tdata[42:35]);
          cmp("data_last", e.data_last, m_tlast);
        end
      end
      // one long hold-off so the block backs up onto its input
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 200) begin
        hold_done = 1;
        hold_left = 300;
        m_tready <= 1'b0;
      end else if (results_seen > 900 && results_seen < 1300) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= $urandom_range(0, 99) >= 33;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  dir_row_t dir_rows[] = '{
    '{KIND_XCHG, 8'h00, 32'h0, 16'h0, 8'h00, 1, 1'b0, RC_OK, 3'd0},
    '{KIND_TICK, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1, 1'b0, RC_OK, 3'd0},
    '{KIND_READ, 8'h00, 32'h0, 16'h1, 8'h00, 1, 1'b1, RC_NRDY, 3'd0},
    '{KIND_READ, 8'h00, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1, 1'b1, RC_NRDY, 3'd0},
    '{KIND_READ, 8'h00, 32'h1234, 16'h0, 8'h00, 1, 1'b1, RC_PARAM, 3'd0},
    '{KIND_READ, 8'hFF, 32'h0, 16'h1, 8'h00, 1, 1'b1, RC_PARAM, 3'd0},
    '{KIND_INIT, 8'hFF, 32'h0, 16'h0, 8'h00, 1, 1'b1, RC_NRDY, 3'd1},
    '{KIND_INIT, 8'h01, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1, 1'b1, RC_NRDY, 3'd1},
    '{KIND_INIT, 8'h00, 32'h0, 16'h0, 8'h00, 1, 1'b0, RC_OK, 3'd0},
    '{KIND_READ, 8'h00, 32'h0, 16'h1, 8'h00, 1, 1'b1, RC_BUSY, 3'd0},
    '{KIND_INIT, 8'h00, 32'h0, 16'h0, 8'h00, 1, 1'b1, RC_BUSY, 3'd0},
    '{KIND_XCHG, 8'h00, 32'h0, 16'h0, 8'hFF, 1, 1'b0, RC_OK, 3'd0},
    '{KIND_XCHG, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 8'h00, 1, 1'b0, RC_OK, 3'd0},
    '{KIND_TICK, 8'h00, 32'h0, 16'h0, 8'h00, 1, 1'b0, RC_OK, 3'd0}
  };

  initial begin
    item_t it;
    int unsigned regs[6];
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it.kind = dir_rows[i].kind;
      it.drive = dir_rows[i].drive;
      it.sector = dir_rows[i].sector;
      it.block_count = dir_rows[i].count;
      it.rx_byte = dir_rows[i].rx;
      send_item(it, dir_rows[i].chk, dir_rows[i]);
    end
    // finish the power-up with the reset settings
    run_random(250);
    wait_drained();

    // small random limits, so timeouts and retries fire often
    regs = '{$urandom_range(1, 4), $urandom_range(1, 40), $urandom_range(1, 6),
             $urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(0, 3)};
    write_regs(regs);
    run_random(300);
    wait_drained();

    // zero limits act as one, zero delays skip the wait
    regs = '{1, 1, 0, 0, 0, 0};
    write_regs(regs);
    run_random(200);
    wait_drained();

    // upper extremes of the limits, with short delays
    regs = '{65535, 65535, 255, 15, 40, 40};
    write_regs(regs);
    run_random(200);
    wait_drained();

    regs = '{$urandom_range(1, 65535), $urandom_range(1, 65535), $urandom_range(1, 255),
             $urandom_range(1, 15), $urandom_range(0, 20), $urandom_range(0, 20)};
    write_regs(regs);
    run_random(250);
    wait_drained();

    if (fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
